// ===== rtl/blth_pkg.sv =====
`default_nettype none

package blth_pkg;

   // geometry
   localparam int MAX_SIDE  = 64;
   localparam int ROW_AW    = $clog2(MAX_SIDE);
   localparam int SIZE_W    = 7;
   localparam int POS_W     = 7;
   localparam int ROW_IDX_W = 6;
   localparam int PIX_W     = 64;
   localparam int COL_W     = 6;
   localparam int COORD_W   = 9;
   localparam int ERR_W     = 12;
   localparam int NPROBE    = 3;

   // stream layout
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;

   // register map
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam logic REG_BOX_W = 1'b0;
   localparam logic REG_BOX_H = 1'b1;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_TRACE = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ERR_W-1:0]   err_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic setup_a;
      logic setup_b;
      logic step;
      logic drain;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic pend;
      logic hit;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/blth_csr.sv =====
`default_nettype none

module blth_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [blth_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [blth_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [blth_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                          csr_pready,
   output      logic [blth_pkg::SIZE_W-1:0]   box_w,
   output      logic [blth_pkg::SIZE_W-1:0]   box_h
);
   import blth_pkg::*;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_BOX_W: width_in  = csr_pwdata[SIZE_W-1:0];
            REG_BOX_H: height_in = csr_pwdata[SIZE_W-1:0];
            default:   width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BOX_W: csr_prdata = {{(CSR_DW-SIZE_W){1'b0}}, width_ff};
         REG_BOX_H: csr_prdata = {{(CSR_DW-SIZE_W){1'b0}}, height_ff};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(MAX_SIDE);
         height_ff <= SIZE_W'(MAX_SIDE);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign box_w = width_ff;
   assign box_h = height_ff;

endmodule

`default_nettype wire

// ===== rtl/blth_ctrl.sv =====
`default_nettype none

module blth_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_kind,
   output      logic                  req_tready,
   input  wire blth_pkg::status_type  status,
   output      blth_pkg::cmd_type     cmd
);
   import blth_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SETUP_A = 4'b0010,
      ST_SETUP_B = 4'b0100,
      ST_WALK    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      finish_now;

   assign req_tready = (state_ff == ST_IDLE);
   assign finish_now = status.hit | (status.at_end & ~status.pend);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == KIND_TRACE) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SETUP_A;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SETUP_A: begin
            cmd.setup_a = 1'b1;
            state_in    = ST_SETUP_B;
         end
         ST_SETUP_B: begin
            cmd.setup_b = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            priority if (finish_now) begin
               if (status.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (!status.at_end) begin
               cmd.step = 1'b1;
            end else begin
               cmd.drain = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/blth_dp.sv =====
`default_nettype none

module blth_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire blth_pkg::cmd_type               cmd,
   output      blth_pkg::status_type            status,
   input  wire logic [blth_pkg::SIZE_W-1:0]     box_w,
   input  wire logic [blth_pkg::SIZE_W-1:0]     box_h,
   input  wire logic [blth_pkg::ROW_IDX_W-1:0]  row_index,
   input  wire logic [blth_pkg::PIX_W-1:0]      row_pixels,
   input  wire logic [blth_pkg::POS_W-1:0]      start_x,
   input  wire logic [blth_pkg::POS_W-1:0]      start_y,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [blth_pkg::POS_W-1:0]      hit_x,
   output      logic [blth_pkg::POS_W-1:0]      hit_y,
   output      logic                            reached_centre
);
   import blth_pkg::*;

   localparam int EXT_W = ERR_W - COORD_W - 1;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_SIDE)) begin
         r = SIZE_W'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic err_type dbl(input coord_type v);
      return $signed({{EXT_W{v[COORD_W-1]}}, v, 1'b0});
   endfunction

   // captured start point
   logic [POS_W-1:0]  sx_ff, sy_ff;

   // line set-up
   logic [SIZE_W-1:0] w_ff, h_ff;
   logic              x_major_ff, x_major_in;
   coord_type         ind_ff, ind_in;
   coord_type         dep_ff, dep_in;
   coord_type         ind_end_ff, ind_end_in;
   coord_type         d_ind_ff, d_ind_in;
   coord_type         d_dep_ff, d_dep_in;
   err_type           inc_only_ff, inc_only_in;
   err_type           inc_both_ff, inc_both_in;
   err_type           d_ff, d_in;

   // probe stage
   logic              pend_ff, pend_in;
   coord_type         p_ind_ff, p_dep_ff;
   logic [COL_W-1:0]  col_ff [NPROBE];
   logic              in_box_ff [NPROBE];
   logic [PIX_W-1:0]  rd_ff [NPROBE];
   logic [PIX_W-1:0]  pix_mem_ff [NPROBE][MAX_SIDE];

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  hit_x_ff, hit_y_ff;
   logic              reached_ff;

   // set-up a
   logic [SIZE_W-1:0] eff_w, eff_h;
   coord_type         cx, cy, sxs, sys, dx, dy, adx, ady;

   // set-up b / walk
   err_type           two_dep, two_ind, inc_o, inc_b, sum_ob;
   logic              sign_neg, take_only;

   // probe addressing
   coord_type         px [NPROBE];
   coord_type         py [NPROBE];
   logic              in_box [NPROBE];
   logic [NPROBE-1:0] probe_bit;
   logic              hit;
   logic              wr_ok;
   logic              at_end;
   logic              out_free;

   // ---------------- set-up a: centre, direction, major axis
   always_comb begin
      eff_w = eff_size(box_w);
      eff_h = eff_size(box_h);
      cx    = $signed({2'b00, eff_w >> 1});
      cy    = $signed({2'b00, eff_h >> 1});
      sxs   = $signed({2'b00, sx_ff});
      sys   = $signed({2'b00, sy_ff});
      dx    = cx - sxs;
      dy    = cy - sys;
      adx   = dx[COORD_W-1] ? -dx : dx;
      ady   = dy[COORD_W-1] ? -dy : dy;
      x_major_in = adx > ady;
      if (x_major_in) begin
         ind_end_in = cx;
         d_ind_in   = dx;
         d_dep_in   = dy;
      end else begin
         ind_end_in = cy;
         d_ind_in   = dy;
         d_dep_in   = dx;
      end
   end

   // ---------------- set-up b: error increments, initial error and step choice
   always_comb begin
      two_dep = dbl(d_dep_ff);
      two_ind = dbl(d_ind_ff);
      inc_o   = (d_ind_ff > 0) ? two_dep : -two_dep;
      inc_b   = inc_o - ((d_dep_ff > 0) ? two_ind : -two_ind);
      sum_ob  = inc_o + inc_b;
      sign_neg = (d_ind_ff > 0 && d_dep_ff > 0) || (d_ind_ff < 0 && d_dep_ff < 0) ||
                 (d_dep_ff == 0 && d_ind_ff < 0);
      take_only = sign_neg ? (d_ff < 0) : (d_ff > 0);
      inc_only_in = inc_o;
      inc_both_in = inc_b;
   end

   // ---------------- walker registers
   always_comb begin
      ind_in = ind_ff;
      dep_in = dep_ff;
      d_in   = d_ff;
      if (cmd.setup_a) begin
         ind_in = x_major_in ? sxs : sys;
         dep_in = x_major_in ? sys : sxs;
      end else if (cmd.setup_b) begin
         d_in = sum_ob >>> 1;
      end else if (cmd.step) begin
         ind_in = (d_ind_ff < 0) ? ind_ff - coord_type'(1) : ind_ff + coord_type'(1);
         if (take_only) begin
            d_in = d_ff + inc_only_ff;
         end else begin
            d_in   = d_ff + inc_both_ff;
            dep_in = (d_dep_ff < 0) ? dep_ff - coord_type'(1) : dep_ff + coord_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sx_ff <= start_x;
         sy_ff <= start_y;
      end
      if (cmd.setup_a) begin
         w_ff       <= eff_w;
         h_ff       <= eff_h;
         x_major_ff <= x_major_in;
         ind_end_ff <= ind_end_in;
         d_ind_ff   <= d_ind_in;
         d_dep_ff   <= d_dep_in;
      end
      if (cmd.setup_b) begin
         inc_only_ff <= inc_only_in;
         inc_both_ff <= inc_both_in;
      end
      ind_ff <= ind_in;
      dep_ff <= dep_in;
      d_ff   <= d_in;
   end

   assign at_end = (ind_ff == ind_end_ff);

   // ---------------- probes: the line pixel and its two neighbours
   always_comb begin
      for (int k = 0; k < NPROBE; k++) begin
         if (x_major_ff) begin
            px[k] = ind_ff;
            py[k] = dep_ff + coord_type'(k - 1);
         end else begin
            px[k] = dep_ff + coord_type'(k - 1);
            py[k] = ind_ff;
         end
         in_box[k] = !px[k][COORD_W-1] && !py[k][COORD_W-1] &&
                     (px[k] < $signed({2'b00, w_ff})) &&
                     (py[k] < $signed({2'b00, h_ff}));
      end
   end

   assign wr_ok = (int'(row_index) < MAX_SIDE);

   // one bitmap copy per probe, all written alike
   for (genvar k = 0; k < NPROBE; k++) begin : g_copy
      always_ff @(posedge clock) begin
         if (cmd.load && wr_ok) begin
            pix_mem_ff[k][row_index[ROW_AW-1:0]] <= row_pixels;
         end
         if (cmd.step) begin
            rd_ff[k]     <= pix_mem_ff[k][py[k][ROW_AW-1:0]];
            col_ff[k]    <= px[k][COL_W-1:0];
            in_box_ff[k] <= in_box[k];
         end
      end
      assign probe_bit[k] = in_box_ff[k] & rd_ff[k][col_ff[k]];
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         p_ind_ff <= ind_ff;
         p_dep_ff <= dep_ff;
      end
   end

   assign hit = pend_ff & (|probe_bit);

   always_comb begin
      pend_in = pend_ff;
      if (cmd.step) begin
         pend_in = 1'b1;
      end else if (cmd.drain || cmd.finish || cmd.capture) begin
         pend_in = 1'b0;
      end
   end

   // ---------------- result register
   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (hit) begin
            hit_x_ff   <= x_major_ff ? p_ind_ff[POS_W-1:0] : p_dep_ff[POS_W-1:0];
            hit_y_ff   <= x_major_ff ? p_dep_ff[POS_W-1:0] : p_ind_ff[POS_W-1:0];
            reached_ff <= 1'b0;
         end else begin
            hit_x_ff   <= x_major_ff ? ind_ff[POS_W-1:0] : dep_ff[POS_W-1:0];
            hit_y_ff   <= x_major_ff ? dep_ff[POS_W-1:0] : ind_ff[POS_W-1:0];
            reached_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.at_end   = at_end;
   assign status.pend     = pend_ff;
   assign status.hit      = hit;
   assign status.out_free = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign hit_x          = hit_x_ff;
   assign hit_y          = hit_y_ff;
   assign reached_centre = reached_ff;

   // ---------------- checks
   a_step_not_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !at_end)
      else $error("walk stepped past the centre");

   a_step_sets_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> pend_ff)
      else $error("probe not pending after a step");

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result written over an untaken word");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished trace gave no result");

endmodule

`default_nettype wire

// ===== rtl/bitmap_line_trace_first_hit.sv =====
// a load word is written at its acceptance edge; a trace word is captured, then passes set-up a
// and set-up b and walks towards the centre, stopping on a set pixel at a probe, or at the centre
// once the last probe has cleared; a trace that starts on the centre finishes straight after set-up
// the next word is taken once a trace result is written and the controller is back in idle, so one
// trace at a time; loads go one per cycle while no trace runs; a stalled result holds the walk
// reset: control and result valid cleared, both size registers set to 64; bitmap undefined until loaded
`default_nettype none

module bitmap_line_trace_first_hit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // row_index[5:0], row_pixels[69:6], start_x[76:70], start_y[83:77], zero pad
   input  wire logic [blth_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[0]: 0 load row, 1 trace
   input  wire logic                               req_tuser,
   // response stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hit_x[6:0], hit_y[13:7], zero pad
   output      logic [blth_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // reached_centre[0]
   output      logic                               rsp_tuser,
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [blth_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [blth_pkg::CSR_DW-1:0]        csr_pwdata,
   output      logic [blth_pkg::CSR_DW-1:0]        csr_prdata,
   output      logic                               csr_pready
);
   import blth_pkg::*;

   // unpacked request fields
   logic [ROW_IDX_W-1:0] row_index;
   logic [PIX_W-1:0]     row_pixels;
   logic [POS_W-1:0]     start_x;
   logic [POS_W-1:0]     start_y;

   // node size from the register block
   logic [SIZE_W-1:0]    box_w;
   logic [SIZE_W-1:0]    box_h;

   // controller <-> datapath
   cmd_type              cmd;
   status_type           status;

   // result fields
   logic [POS_W-1:0]     hit_x;
   logic [POS_W-1:0]     hit_y;
   logic                 reached_centre;

   assign row_index  = req_tdata[ROW_IDX_W-1:0];
   assign row_pixels = req_tdata[ROW_IDX_W +: PIX_W];
   assign start_x    = req_tdata[ROW_IDX_W + PIX_W +: POS_W];
   assign start_y    = req_tdata[ROW_IDX_W + PIX_W + POS_W +: POS_W];

   // size registers; the user must write them only while idle, the block does not enforce it
   blth_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .box_w       (box_w),
      .box_h       (box_h)
   );

   // sequencer: idle, set-up a and set-up b, then the walk loop
   blth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // bitmap copies, bresenham walker, probe stage and output register
   blth_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .box_w          (box_w),
      .box_h          (box_h),
      .row_index      (row_index),
      .row_pixels     (row_pixels),
      .start_x        (start_x),
      .start_y        (start_y),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .hit_x          (hit_x),
      .hit_y          (hit_y),
      .reached_centre (reached_centre)
   );

   // pack the response word
   assign rsp_tdata = {{(RSP_DATA_W - 2*POS_W){1'b0}}, hit_y, hit_x};
   assign rsp_tuser = reached_centre;

endmodule

`default_nettype wire

// ===== bench/trace_result_checker.sv =====
module trace_result_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // row_index, row_pixels, start_x, start_y, zero pad
   input  wire logic [blth_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hit_x, hit_y, zero pad
   input  wire logic [blth_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // reached_centre
   input  wire logic                              rsp_tuser,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [blth_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [blth_pkg::CSR_DW-1:0]       csr_pwdata,
   input  wire logic [blth_pkg::CSR_DW-1:0]       csr_prdata,
   input  wire logic                              csr_pready,
   output int                                     fault_count,
   output int                                     points_due,
   output int                                     hits_seen,
   output int                                     centre_runs
);
   timeunit 1ns;
   timeprecision 1ps;
   import blth_pkg::*;

   localparam logic [CSR_AW-1:0] WIDTH_ADDR  = {REG_BOX_W, 2'b00};
   localparam logic [CSR_AW-1:0] HEIGHT_ADDR = {REG_BOX_H, 2'b00};
   localparam int START_X_LSB = ROW_IDX_W + PIX_W;
   localparam int START_Y_LSB = START_X_LSB + POS_W;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             at_centre;
   } traced_point_type;

   logic [PIX_W-1:0]  pixel_rows [MAX_SIDE];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   traced_point_type  traced_points [$];
   int                faults;
   int                hits;
   int                centres;
   int                result_index;

   function automatic int side_of(input logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
   endfunction

   function automatic int magnitude(input int v);
      return v < 0 ? -v : v;
   endfunction

   // pixels off the bitmap read as clear
   function automatic bit pixel_set(input int x, input int y, input int w, input int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
      return pixel_rows[y][x];
   endfunction

   // bresenham walk from the start towards the centre, probing across the minor axis
   function automatic traced_point_type walk_to_first_hit(input logic [POS_W-1:0] start_x,
                                                          input logic [POS_W-1:0] start_y);
      int w, h, sx, sy, cx, cy;
      int ind, dep, ind_end, d_ind, d_dep;
      int inc_only, inc_both, d, step_ind, step_dep;
      bit x_major, sign_neg, found;
      traced_point_type pt;
      w  = side_of(width_reg);
      h  = side_of(height_reg);
      sx = int'(start_x);
      sy = int'(start_y);
      cx = w / 2;
      cy = h / 2;
      x_major = magnitude(cx - sx) > magnitude(cy - sy);
      if (x_major) begin
         ind = sx; dep = sy; ind_end = cx; d_ind = cx - sx; d_dep = cy - sy;
      end else begin
         ind = sy; dep = sx; ind_end = cy; d_ind = cy - sy; d_dep = cx - sx;
      end
      inc_only = d_ind > 0 ? 2 * d_dep : -2 * d_dep;
      inc_both = inc_only - (d_dep > 0 ? 2 * d_ind : -2 * d_ind);
      d        = (inc_only + inc_both) / 2;
      step_ind = d_ind >= 0 ? 1 : -1;
      step_dep = d_dep >= 0 ? 1 : -1;
      sign_neg = (d_ind > 0 && d_dep > 0) || (d_ind < 0 && d_dep < 0) ||
                 (d_dep == 0 && d_ind < 0);
      found = 1'b0;
      while (!found && ind != ind_end) begin
         if (x_major)
            found = pixel_set(ind, dep, w, h) || pixel_set(ind, dep - 1, w, h) ||
                    pixel_set(ind, dep + 1, w, h);
         else
            found = pixel_set(dep, ind, w, h) || pixel_set(dep - 1, ind, w, h) ||
                    pixel_set(dep + 1, ind, w, h);
         if (!found) begin
            if (sign_neg ? (d < 0) : (d > 0)) begin
               d += inc_only;
            end else begin
               d += inc_both;
               dep += step_dep;
            end
            ind += step_ind;
         end
      end
      pt.x         = x_major ? ind[POS_W-1:0] : dep[POS_W-1:0];
      pt.y         = x_major ? dep[POS_W-1:0] : ind[POS_W-1:0];
      pt.at_centre = !found;
      return pt;
   endfunction

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin : watch
      traced_point_type got, want;
      logic [SIZE_W-1:0] stored;
      if (reset) begin
         width_reg  = SIZE_W'(MAX_SIDE);
         height_reg = SIZE_W'(MAX_SIDE);
         traced_points.delete();
      end else begin
         // results first: none can belong to a trace taken on this same edge
         if (rsp_tvalid && rsp_tready) begin
            got.x         = rsp_tdata[POS_W-1:0];
            got.y         = rsp_tdata[2*POS_W-1:POS_W];
            got.at_centre = rsp_tuser;
            if (traced_points.size() == 0) begin
               note_fault($sformatf("result (%0d,%0d) centre %0b with no trace waiting",
                                    got.x, got.y, got.at_centre));
            end else begin
               want = traced_points.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.at_centre !== want.at_centre)
                  note_fault($sformatf("trace %0d expected (%0d,%0d) centre %0b, got (%0d,%0d) centre %0b",
                                       result_index, want.x, want.y, want.at_centre,
                                       got.x, got.y, got.at_centre));
               else if (got.at_centre)
                  centres++;
               else
                  hits++;
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_LOAD)
               pixel_rows[req_tdata[ROW_IDX_W-1:0]] = req_tdata[ROW_IDX_W +: PIX_W];
            else
               traced_points.push_back(walk_to_first_hit(req_tdata[START_X_LSB +: POS_W],
                                                         req_tdata[START_Y_LSB +: POS_W]));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr)
                  WIDTH_ADDR:  width_reg  = csr_pwdata[SIZE_W-1:0];
                  HEIGHT_ADDR: height_reg = csr_pwdata[SIZE_W-1:0];
                  default: ;
               endcase
            end else begin
               stored = (csr_paddr == WIDTH_ADDR) ? width_reg : height_reg;
               if (csr_prdata[SIZE_W-1:0] !== stored)
                  note_fault($sformatf("register at %0d expected %0d, read %0d",
                                       csr_paddr, stored, csr_prdata[SIZE_W-1:0]));
            end
         end
      end
      fault_count <= faults;
      points_due  <= traced_points.size();
      hits_seen   <= hits;
      centre_runs <= centres;
   end

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import blth_pkg::*;

   // cycles with no word moving on any port before the run is given up
   localparam int WATCHDOG_LIMIT  = 4000;
   // result side held off once for this long so the block backs up
   localparam int HOLD_OFF_CYCLES = 400;
   // quiet cycles before the size registers change
   localparam int LOAD_SETTLE     = 8;
   localparam int TAIL_CYCLES     = 100;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 62;
   localparam logic [CSR_AW-1:0] WIDTH_ADDR  = {REG_BOX_W, 2'b00};
   localparam logic [CSR_AW-1:0] HEIGHT_ADDR = {REG_BOX_H, 2'b00};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr   = '0;
   logic [CSR_DW-1:0]     csr_pwdata  = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;
   logic                  hold_off_go = 1'b0;

   int fault_count;
   int points_due;
   int hits_seen;
   int centre_runs;
   int stall_cycles = 0;
   int loads_sent   = 0;
   int traces_sent  = 0;
   int settings_made = 0;
   // effective node size as the block sees it, only used to aim start points
   int eff_w = MAX_SIDE;
   int eff_h = MAX_SIDE;

   bitmap_line_trace_first_hit dut (.*);

   trace_result_checker checker_inst (.*);

   always #2 clock = ~clock;

   // watchdog: any word moving on any port restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", stall_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // layout of a request word, lowest field first
   function automatic logic [REQ_DATA_W-1:0] pack_word(input logic [ROW_IDX_W-1:0] row,
                                                       input logic [PIX_W-1:0]     pixels,
                                                       input logic [POS_W-1:0]     sx,
                                                       input logic [POS_W-1:0]     sy);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[ROW_IDX_W-1:0]                  = row;
      word[ROW_IDX_W +: PIX_W]             = pixels;
      word[ROW_IDX_W + PIX_W +: POS_W]     = sx;
      word[ROW_IDX_W + PIX_W + POS_W +: POS_W] = sy;
      return word;
   endfunction

   // row contents, weighted towards sparse so that many walks run a long way
   function automatic logic [PIX_W-1:0] row_pattern();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:          return '0;
         1, 2, 3, 4: return 64'd1 << $urandom_range(0, PIX_W - 1);
         5, 6, 7:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         8:          return {$urandom, $urandom};
         default:    return '1;
      endcase
   endfunction

   // register values: mostly legal, now and then zero or above the largest side
   function automatic int random_size();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 0;
         1:       return $urandom_range(MAX_SIDE + 1, 127);
         2:       return MAX_SIDE;
         default: return $urandom_range(1, MAX_SIDE);
      endcase
   endfunction

   // one word on the request side; valid stays up afterwards for back-to-back words
   task automatic offer(input logic kind, input logic [REQ_DATA_W-1:0] word);
      req_tuser  <= kind;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_LOAD) loads_sent++;
      else traces_sent++;
   endtask

   task automatic load_row(input logic [ROW_IDX_W-1:0] row, input logic [PIX_W-1:0] pixels);
      offer(KIND_LOAD, pack_word(row, pixels, POS_W'($urandom), POS_W'($urandom)));
   endtask

   // the row fields are don't-care on a trace, so they carry noise
   task automatic trace_from(input int sx, input int sy);
      offer(KIND_TRACE, pack_word(ROW_IDX_W'($urandom), {$urandom, $urandom},
                                  POS_W'(sx), POS_W'(sy)));
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // sender goes quiet until every trace has come back and any load has landed
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (points_due != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   // setup and access phase; the idle cycle after keeps psel to one update a step
   task automatic csr_access(input logic write, input logic [CSR_AW-1:0] addr,
                             input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // new node size, written only with the block idle, then read back
   task automatic set_size(input int w, input int h);
      drain();
      csr_access(1'b1, WIDTH_ADDR, w);
      csr_access(1'b1, HEIGHT_ADDR, h);
      csr_access(1'b0, WIDTH_ADDR, 0);
      csr_access(1'b0, HEIGHT_ADDR, 0);
      eff_w = (w == 0) ? 1 : (w > MAX_SIDE) ? MAX_SIDE : w;
      eff_h = (h == 0) ? 1 : (h > MAX_SIDE) ? MAX_SIDE : h;
      settings_made++;
   endtask

   // mostly border starts, some anywhere, some close to or on the centre
   task automatic pick_start(output int sx, output int sy);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         if ($urandom_range(0, 1)) begin
            sx = $urandom_range(0, 1) ? eff_w : 0;
            sy = $urandom_range(0, eff_h);
         end else begin
            sx = $urandom_range(0, eff_w);
            sy = $urandom_range(0, 1) ? eff_h : 0;
         end
      end else if (sel < 80) begin
         sx = $urandom_range(0, MAX_SIDE);
         sy = $urandom_range(0, MAX_SIDE);
      end else if (sel < 95) begin
         sx = eff_w / 2 + int'($urandom_range(0, 4)) - 2;
         sy = eff_h / 2 + int'($urandom_range(0, 4)) - 2;
         if (sx < 0) sx = 0;
         if (sy < 0) sy = 0;
      end else begin
         sx = eff_w / 2;
         sy = eff_h / 2;
      end
   endtask

   // result side: random stall patterns, plus one long hold-off when asked for
   initial begin : receiver
      int span;
      int mode;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= ($urandom_range(0, 9) != 0);
                  default: rsp_tready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int sx, sy;
      int burst_left;
      bit steady;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every row gets written before any trace can read it
      for (int r = 0; r < MAX_SIDE; r++) load_row(ROW_IDX_W'(r), '0);

      // empty bitmap at full size: walks from the corners, the axes and the centre itself
      trace_from(0, 0);
      trace_from(MAX_SIDE, MAX_SIDE);
      trace_from(MAX_SIDE / 2, MAX_SIDE / 2);
      trace_from(0, MAX_SIDE / 2);
      trace_from(MAX_SIDE / 2, MAX_SIDE);
      trace_from(MAX_SIDE, 5);

      // outer rows and one pixel mid-way: hits at the start, beside the line, past the edge
      load_row(ROW_IDX_W'(0), 64'h8000_0000_0000_0001);
      load_row(ROW_IDX_W'(MAX_SIDE - 1), '1);
      load_row(ROW_IDX_W'(MAX_SIDE / 2), 64'd1 << 40);
      trace_from(0, 0);
      trace_from(MAX_SIDE, 0);
      trace_from(20, MAX_SIDE);
      trace_from(MAX_SIDE, MAX_SIDE / 2);

      // size registers at zero and at their top value
      set_size(0, 127);
      trace_from(0, 0);
      trace_from(MAX_SIDE, MAX_SIDE);
      set_size(127, 0);
      trace_from(MAX_SIDE, 0);
      trace_from(0, MAX_SIDE);

      // one by one node: centre at the origin
      set_size(1, 1);
      trace_from(0, 0);
      trace_from(MAX_SIDE, MAX_SIDE);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_size(MAX_SIDE, MAX_SIDE);
            1:       set_size(1, 1);
            2:       set_size(MAX_SIDE, 1);
            3:       set_size(1, MAX_SIDE);
            4:       set_size(127, MAX_SIDE + 1);
            5:       set_size(2, 3);
            default: set_size(random_size(), random_size());
         endcase
         // the receiver backs off for a long stretch while words keep coming
         if (p == 1) hold_off_go <= 1'b1;
         steady = (p % 3 == 2);
         burst_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 5 && i == PHASE_ITEMS / 2) drain();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (!steady) rest($urandom_range(0, 10));
            end
            burst_left--;
            if ($urandom_range(0, 9) < 3) begin
               load_row(ROW_IDX_W'($urandom_range(0, MAX_SIDE - 1)), row_pattern());
            end else begin
               pick_start(sx, sy);
               trace_from(sx, sy);
            end
         end
      end

      // wait for the last results, then a quiet tail
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (points_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d row loads and %0d traces over %0d node sizes",
               loads_sent, traces_sent, settings_made);
      $display("%0d traces stopped on a set pixel, %0d walked through to the centre",
               hits_seen, centre_runs);
      if (fault_count == 0 && points_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
